@@ src/rrhit_pkg.sv @@
package rrhit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 3;

    // configuration register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_RECT_WIDTH   = 3'd2,
        REG_RECT_HEIGHT  = 3'd3,
        REG_RADII_TL     = 3'd4,
        REG_RADII_TR     = 3'd5,
        REG_RADII_BR     = 3'd6,
        REG_RADII_BL     = 3'd7
    } cfg_reg_t;

    // per-beat control travelling down the pipe
    typedef struct packed {
        logic valid;
        logic need_ell;
        logic fixed_res;
    } ctl_t;

endpackage

@@ src/rrhit_region.sv @@
module rrhit_region #(
    parameter int COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  origin_x,
    input  logic signed [COORD_BITS-1:0]  origin_y,
    input  logic [COORD_BITS-2:0]         rect_width,
    input  logic [COORD_BITS-2:0]         rect_height,
    input  logic [2*COORD_BITS-3:0]       radii_top_left,
    input  logic [2*COORD_BITS-3:0]       radii_top_right,
    input  logic [2*COORD_BITS-3:0]       radii_bottom_right,
    input  logic [2*COORD_BITS-3:0]       radii_bottom_left,
    output rrhit_pkg::ctl_t               ctl,
    output logic [COORD_BITS-2:0]         rx,
    output logic [COORD_BITS-2:0]         ry,
    output logic [COORD_BITS-2:0]         lx,
    output logic [COORD_BITS-2:0]         ly
);

    localparam int S       = COORD_BITS - 1;
    localparam int W       = COORD_BITS + 3;
    localparam int EXT     = W - COORD_BITS;
    localparam int NCORNER = 4;
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    logic [2*S-1:0]       radii [NCORNER];
    logic signed [W-1:0]  px_e, py_e, left_e, top_e, wid_e, hgt_e;
    logic signed [W-1:0]  dx_left, dx_right, dy_top, dy_bot;
    logic signed [W-1:0]  rx_e [NCORNER];
    logic signed [W-1:0]  ry_e [NCORNER];
    logic                 in_bounds;

    logic                 valid_s1_reg, valid_s1_next;
    logic                 in_bounds_s1_reg, in_bounds_s1_next;
    logic signed [W-1:0]  lx_s1_reg [NCORNER];
    logic signed [W-1:0]  lx_s1_next [NCORNER];
    logic signed [W-1:0]  ly_s1_reg [NCORNER];
    logic signed [W-1:0]  ly_s1_next [NCORNER];

    logic [NCORNER-1:0]   hit;
    logic [1:0]           sel;
    logic                 any_hit;

    rrhit_pkg::ctl_t      ctl_reg, ctl_next;
    logic [S-1:0]         rx_reg, rx_next, ry_reg, ry_next;
    logic [S-1:0]         lx_reg, lx_next, ly_reg, ly_next;

    assign radii[CORNER_TL] = radii_top_left;
    assign radii[CORNER_TR] = radii_top_right;
    assign radii[CORNER_BR] = radii_bottom_right;
    assign radii[CORNER_BL] = radii_bottom_left;

    // stage 1: offsets from the edges and candidate corner offsets
    assign px_e   = {{EXT{point_x[COORD_BITS-1]}}, point_x};
    assign py_e   = {{EXT{point_y[COORD_BITS-1]}}, point_y};
    assign left_e = {{EXT{origin_x[COORD_BITS-1]}}, origin_x};
    assign top_e  = {{EXT{origin_y[COORD_BITS-1]}}, origin_y};
    assign wid_e  = {{(W-S){1'b0}}, rect_width};
    assign hgt_e  = {{(W-S){1'b0}}, rect_height};

    assign dx_left  = px_e - left_e;
    assign dx_right = dx_left - wid_e;
    assign dy_top   = py_e - top_e;
    assign dy_bot   = dy_top - hgt_e;

    assign in_bounds = !dx_left[W-1] && dx_right[W-1] && !dy_top[W-1] && dy_bot[W-1];

    always_comb
    begin
        for (int c = 0; c < NCORNER; c++)
        begin
            rx_e[c] = {{(W-S){1'b0}}, radii[c][S-1:0]};
            ry_e[c] = {{(W-S){1'b0}}, radii[c][2*S-1:S]};
        end
    end

    always_comb
    begin
        valid_s1_next     = in_valid;
        in_bounds_s1_next = in_bounds;
        lx_s1_next[CORNER_TL] = rx_e[CORNER_TL] - dx_left;
        ly_s1_next[CORNER_TL] = ry_e[CORNER_TL] - dy_top;
        lx_s1_next[CORNER_TR] = dx_right + rx_e[CORNER_TR];
        ly_s1_next[CORNER_TR] = ry_e[CORNER_TR] - dy_top;
        lx_s1_next[CORNER_BR] = dx_right + rx_e[CORNER_BR];
        ly_s1_next[CORNER_BR] = dy_bot + ry_e[CORNER_BR];
        lx_s1_next[CORNER_BL] = rx_e[CORNER_BL] - dx_left;
        ly_s1_next[CORNER_BL] = dy_bot + ry_e[CORNER_BL];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= valid_s1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_bounds_s1_reg <= in_bounds_s1_next;
        for (int c = 0; c < NCORNER; c++)
        begin
            lx_s1_reg[c] <= lx_s1_next[c];
            ly_s1_reg[c] <= ly_s1_next[c];
        end
    end

    // stage 2: corner hit and priority select
    always_comb
    begin
        for (int c = 0; c < NCORNER; c++)
        begin
            hit[c] = !lx_s1_reg[c][W-1] && (lx_s1_reg[c] != '0)
                  && !ly_s1_reg[c][W-1] && (ly_s1_reg[c] != '0);
        end
    end

    always_comb
    begin
        sel     = CORNER_TL;
        any_hit = 1'b1;
        priority if (hit[CORNER_TL])
        begin
            sel = CORNER_TL;
        end
        else if (hit[CORNER_TR])
        begin
            sel = CORNER_TR;
        end
        else if (hit[CORNER_BR])
        begin
            sel = CORNER_BR;
        end
        else if (hit[CORNER_BL])
        begin
            sel = CORNER_BL;
        end
        else
        begin
            any_hit = 1'b0;
        end
    end

    always_comb
    begin
        ctl_next.valid     = valid_s1_reg;
        ctl_next.need_ell  = in_bounds_s1_reg && any_hit;
        ctl_next.fixed_res = in_bounds_s1_reg && !any_hit;
        lx_next = lx_s1_reg[sel][S-1:0];
        ly_next = ly_s1_reg[sel][S-1:0];
        rx_next = radii[sel][S-1:0];
        ry_next = radii[sel][2*S-1:S];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        lx_reg <= lx_next;
        ly_reg <= ly_next;
    end

    assign ctl = ctl_reg;
    assign rx  = rx_reg;
    assign ry  = ry_reg;
    assign lx  = lx_reg;
    assign ly  = ly_reg;

    // a selected corner always has the point strictly inside its radius box
    a_corner_offsets_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid && ctl_reg.need_ell |-> (lx_reg != '0) && (ly_reg != '0))
        else $error("corner selected with zero local offset");

endmodule

@@ src/rrhit_ellipse.sv @@
module rrhit_ellipse #(
    parameter int COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrhit_pkg::ctl_t        ctl_in,
    input  logic [COORD_BITS-2:0]  rx,
    input  logic [COORD_BITS-2:0]  ry,
    input  logic [COORD_BITS-2:0]  lx,
    input  logic [COORD_BITS-2:0]  ly,
    output logic                   done,
    output logic                   inside_res
);

    localparam int S = COORD_BITS - 1;
    localparam int P = 2 * S;
    localparam int Q = 4 * S;

    rrhit_pkg::ctl_t  ctl_s3_reg, ctl_s4_reg;
    logic [P-1:0]     a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [Q-1:0]     a2_reg, a2_next, b2_reg, b2_next, c2_reg, c2_next;
    logic [Q:0]       sum;
    logic             le;
    logic             done_reg, done_next;
    logic             inside_reg, inside_next;

    // stage 3: cross products
    always_comb
    begin
        a_next = P'(ry) * P'(lx);
        b_next = P'(rx) * P'(ly);
        c_next = P'(rx) * P'(ry);
    end

    // stage 4: squares
    always_comb
    begin
        a2_next = Q'(a_reg) * Q'(a_reg);
        b2_next = Q'(b_reg) * Q'(b_reg);
        c2_next = Q'(c_reg) * Q'(c_reg);
    end

    // stage 5: sum and compare
    always_comb
    begin
        sum         = (Q+1)'(a2_reg) + (Q+1)'(b2_reg);
        le          = sum <= (Q+1)'(c2_reg);
        done_next   = ctl_s4_reg.valid;
        inside_next = ctl_s4_reg.need_ell ? le : ctl_s4_reg.fixed_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s3_reg <= '0;
            ctl_s4_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ctl_s3_reg <= ctl_in;
            ctl_s4_reg <= ctl_s3_reg;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        a2_reg     <= a2_next;
        b2_reg     <= b2_next;
        c2_reg     <= c2_next;
        inside_reg <= inside_next;
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

endmodule

@@ src/rounded_rect_point_hit_test.sv @@
// result: a point taken at one clock edge has its result on inside_res, marked by done,
// for a single cycle once it has passed five register stages
// throughput: one point per clock, sustained; busy stays low, the pipe never stalls
// the receiver cannot hold results off: done is a one-cycle strobe per beat
// reset: rst_n asynchronous, active low; clears pipe valid bits and all config registers
module rounded_rect_point_hit_test #(
    parameter int COORD_BITS = rrhit_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          point_x,
    input  logic signed [COORD_BITS-1:0]          point_y,
    input  logic                                  cfg_we,
    input  logic [rrhit_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [2*COORD_BITS-3:0]               cfg_wdata,
    output logic                                  done,
    output logic                                  inside_res
);

    localparam int S = COORD_BITS - 1;

    // configuration registers, written by the user only while the pipe is empty; not enforced
    logic signed [COORD_BITS-1:0]  origin_x_reg, origin_x_next;
    logic signed [COORD_BITS-1:0]  origin_y_reg, origin_y_next;
    logic [S-1:0]                  width_reg, width_next;
    logic [S-1:0]                  height_reg, height_next;
    logic [2*S-1:0]                radii_tl_reg, radii_tl_next;
    logic [2*S-1:0]                radii_tr_reg, radii_tr_next;
    logic [2*S-1:0]                radii_br_reg, radii_br_next;
    logic [2*S-1:0]                radii_bl_reg, radii_bl_next;

    logic                          accept;
    rrhit_pkg::ctl_t               rgn_ctl;
    logic [S-1:0]                  rgn_rx, rgn_ry, rgn_lx, rgn_ly;

    // every cycle can take a beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        radii_tl_next = radii_tl_reg;
        radii_tr_next = radii_tr_reg;
        radii_br_next = radii_br_reg;
        radii_bl_next = radii_bl_reg;
        if (cfg_we)
        begin
            unique case (rrhit_pkg::cfg_reg_t'(cfg_index))
                rrhit_pkg::REG_ORIGIN_X:    origin_x_next = cfg_wdata[COORD_BITS-1:0];
                rrhit_pkg::REG_ORIGIN_Y:    origin_y_next = cfg_wdata[COORD_BITS-1:0];
                rrhit_pkg::REG_RECT_WIDTH:  width_next    = cfg_wdata[S-1:0];
                rrhit_pkg::REG_RECT_HEIGHT: height_next   = cfg_wdata[S-1:0];
                rrhit_pkg::REG_RADII_TL:    radii_tl_next = cfg_wdata;
                rrhit_pkg::REG_RADII_TR:    radii_tr_next = cfg_wdata;
                rrhit_pkg::REG_RADII_BR:    radii_br_next = cfg_wdata;
                rrhit_pkg::REG_RADII_BL:    radii_bl_next = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            radii_tl_reg <= '0;
            radii_tr_reg <= '0;
            radii_br_reg <= '0;
            radii_bl_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            radii_tl_reg <= radii_tl_next;
            radii_tr_reg <= radii_tr_next;
            radii_br_reg <= radii_br_next;
            radii_bl_reg <= radii_bl_next;
        end
    end

    // stages 1-2: bounds test, corner offsets, first-matching corner
    rrhit_region #(
        .COORD_BITS (COORD_BITS)
    ) u_region (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (accept),
        .point_x            (point_x),
        .point_y            (point_y),
        .origin_x           (origin_x_reg),
        .origin_y           (origin_y_reg),
        .rect_width         (width_reg),
        .rect_height        (height_reg),
        .radii_top_left     (radii_tl_reg),
        .radii_top_right    (radii_tr_reg),
        .radii_bottom_right (radii_br_reg),
        .radii_bottom_left  (radii_bl_reg),
        .ctl                (rgn_ctl),
        .rx                 (rgn_rx),
        .ry                 (rgn_ry),
        .lx                 (rgn_lx),
        .ly                 (rgn_ly)
    );

    // stages 3-5: exact ellipse inequality, ry^2*lx^2 + rx^2*ly^2 <= (rx*ry)^2
    rrhit_ellipse #(
        .COORD_BITS (COORD_BITS)
    ) u_ellipse (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (rgn_ctl),
        .rx         (rgn_rx),
        .ry         (rgn_ry),
        .lx         (rgn_lx),
        .ly         (rgn_ly),
        .done       (done),
        .inside_res (inside_res)
    );

    // every beat taken gives exactly one result
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted beat produced no result");

    a_done_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result strobe without an accepted beat");

    // the bounds test happens before the corner select
    a_region_valid_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        rgn_ctl.valid |-> $past(accept, 2))
        else $error("region stage valid without an accepted beat");

endmodule

@@ verif/rounded_rect_point_hit_test_test.sv @@
module rounded_rect_point_hit_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    // corner slots, in the order the block looks at them
    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    // one full set of rectangle registers, as the stimulus chooses it
    typedef struct packed {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [3:0][14:0]   rx;
        logic [3:0][14:0]   ry;
    } shape_t;

    // accepted point together with its predicted answer
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 hit;
    } hit_record_t;

    // predicts the mask bit for each accepted point and checks the results in order
    class hit_checker;
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic [14:0]        size_w;
        logic [14:0]        size_h;
        logic [29:0]        corner_radii [4];
        hit_record_t        expected_hits [$];
        int                 failures;

        function new();
            org_x = '0;
            org_y = '0;
            size_w = '0;
            size_h = '0;
            foreach (corner_radii[c])
                corner_radii[c] = '0;
            failures = 0;
        endfunction

        // surplus bits above each register's width are dropped
        function void write_reg(rrhit_pkg::cfg_reg_t idx, logic [29:0] value);
            case (idx)
                rrhit_pkg::REG_ORIGIN_X:    org_x = value[15:0];
                rrhit_pkg::REG_ORIGIN_Y:    org_y = value[15:0];
                rrhit_pkg::REG_RECT_WIDTH:  size_w = value[14:0];
                rrhit_pkg::REG_RECT_HEIGHT: size_h = value[14:0];
                rrhit_pkg::REG_RADII_TL:    corner_radii[CORNER_TL] = value;
                rrhit_pkg::REG_RADII_TR:    corner_radii[CORNER_TR] = value;
                rrhit_pkg::REG_RADII_BR:    corner_radii[CORNER_BR] = value;
                rrhit_pkg::REG_RADII_BL:    corner_radii[CORNER_BL] = value;
                default: ;
            endcase
        endfunction

        // ry^2*lx^2 + rx^2*ly^2 <= rx^2*ry^2, exact
        function bit ellipse_holds(longint rx, longint ry, longint lx, longint ly);
            bit [127:0] a;
            bit [127:0] b;
            bit [127:0] c;
            a = 128'(ry * lx);
            b = 128'(rx * ly);
            c = 128'(rx * ry);
            a = a * a;
            b = b * b;
            c = c * c;
            return (a + b) <= c;
        endfunction

        function bit predict_hit(logic signed [15:0] x, logic signed [15:0] y);
            longint px, py, left, top, right, bottom, lx, ly;
            longint rx [4];
            longint ry [4];
            int     corner;
            px = longint'(x);
            py = longint'(y);
            left = longint'(org_x);
            top = longint'(org_y);
            right = left + longint'(size_w);
            bottom = top + longint'(size_h);
            foreach (corner_radii[c])
            begin
                rx[c] = longint'(corner_radii[c][14:0]);
                ry[c] = longint'(corner_radii[c][29:15]);
            end
            if (!(px >= left && px < right && py >= top && py < bottom))
                return 1'b0;
            if (px < left + rx[CORNER_TL] && py < top + ry[CORNER_TL])
            begin
                corner = CORNER_TL;
                lx = left + rx[corner] - px;
                ly = top + ry[corner] - py;
            end
            else if (px > right - rx[CORNER_TR] && py < top + ry[CORNER_TR])
            begin
                corner = CORNER_TR;
                lx = px - right + rx[corner];
                ly = top + ry[corner] - py;
            end
            else if (px > right - rx[CORNER_BR] && py > bottom - ry[CORNER_BR])
            begin
                corner = CORNER_BR;
                lx = px - right + rx[corner];
                ly = py - bottom + ry[corner];
            end
            else if (px < left + rx[CORNER_BL] && py > bottom - ry[CORNER_BL])
            begin
                corner = CORNER_BL;
                lx = left + rx[corner] - px;
                ly = py - bottom + ry[corner];
            end
            else
                return 1'b1;
            return ellipse_holds(rx[corner], ry[corner], lx, ly);
        endfunction

        function void note_point(logic signed [15:0] x, logic signed [15:0] y);
            hit_record_t rec;
            rec.x = x;
            rec.y = y;
            rec.hit = predict_hit(x, y);
            expected_hits.push_back(rec);
        endfunction

        function void check_result(logic got);
            hit_record_t rec;
            if (expected_hits.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: inside_res=%b", got);
                return;
            end
            rec = expected_hits.pop_front();
            if (got !== rec.hit)
            begin
                failures++;
                if (failures <= 10)
                    $display("inside_res mismatch at point (%0d,%0d): expected %b, got %b",
                             rec.x, rec.y, rec.hit, got);
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        function void close();
            if (expected_hits.size() != 0)
            begin
                $display("%0d expected results never arrived", expected_hits.size());
                failures += expected_hits.size();
            end
        endfunction
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [15:0]                   point_x;
    logic signed [15:0]                   point_y;
    logic                                 cfg_we;
    logic [rrhit_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [29:0]                          cfg_wdata;
    logic                                 done;
    logic                                 inside_res;

    hit_checker hits;
    bit         steady_phase;   // when set, points go in back to back

    rounded_rect_point_hit_test #(
        .COORD_BITS(16)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .point_x(point_x),
        .point_y(point_y),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .inside_res(inside_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // input beat taken when start is high and busy low; result beat whenever done is high
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                hits.note_point(point_x, point_y);
            if (done)
                hits.check_result(inside_res);
        end
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // present one point and hold it until the block takes it
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
        int gap;
        start <= 1'b1;
        point_x <= x;
        point_y <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every outstanding result drain, plus the pipe depth
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (hits.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // leaves cfg_we high; load_shape lowers it after the last write
    task automatic write_reg(input rrhit_pkg::cfg_reg_t idx, input logic [29:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        hits.write_reg(idx, data);
    endtask

    // all eight registers; junk in the bits above the narrow registers
    task automatic load_shape(input shape_t s);
        logic [29:0] junk;
        junk = 30'($urandom);
        write_reg(rrhit_pkg::REG_ORIGIN_X, {junk[29:16], s.ox});
        junk = 30'($urandom);
        write_reg(rrhit_pkg::REG_ORIGIN_Y, {junk[29:16], s.oy});
        junk = 30'($urandom);
        write_reg(rrhit_pkg::REG_RECT_WIDTH, {junk[29:15], s.w});
        junk = 30'($urandom);
        write_reg(rrhit_pkg::REG_RECT_HEIGHT, {junk[29:15], s.h});
        write_reg(rrhit_pkg::REG_RADII_TL, {s.ry[CORNER_TL], s.rx[CORNER_TL]});
        write_reg(rrhit_pkg::REG_RADII_TR, {s.ry[CORNER_TR], s.rx[CORNER_TR]});
        write_reg(rrhit_pkg::REG_RADII_BR, {s.ry[CORNER_BR], s.rx[CORNER_BR]});
        write_reg(rrhit_pkg::REG_RADII_BL, {s.ry[CORNER_BL], s.rx[CORNER_BL]});
        cfg_we <= 1'b0;
    endtask

    // zero size now and then, otherwise mostly moderate, sometimes full range
    function automatic logic [14:0] rand_size();
        int c;
        c = $urandom_range(0, 11);
        if (c == 0)
            return '0;
        if (c == 1)
            return 15'($urandom_range(0, 32767));
        return 15'($urandom_range(16, 3000));
    endfunction

    // zero radius, oversized radius, or one that fits half the span
    function automatic logic [14:0] rand_radius(input int span);
        int c;
        c = $urandom_range(0, 9);
        if (c == 0)
            return '0;
        if (c == 1)
            return 15'($urandom_range(0, 32767));
        return 15'($urandom_range(0, (span / 2 > 0) ? span / 2 : 1));
    endfunction

    function automatic shape_t rand_shape();
        shape_t s;
        s.ox = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : 16'(int'($urandom_range(0, 4000)) - 2000);
        s.oy = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                           : 16'(int'($urandom_range(0, 4000)) - 2000);
        s.w = rand_size();
        s.h = rand_size();
        for (int c = CORNER_TL; c <= CORNER_BL; c++)
        begin
            s.rx[c] = rand_radius(int'(s.w));
            s.ry[c] = rand_radius(int'(s.h));
        end
        return s;
    endfunction

    // mostly inside the bounds (often near an edge), some around them, some anywhere
    function automatic void rand_point(input shape_t s, output logic signed [15:0] x,
                                       output logic signed [15:0] y);
        int c, left, top, xi, yi, cap_x, cap_y;
        left = int'(s.ox);
        top = int'(s.oy);
        c = $urandom_range(0, 9);
        cap_x = (s.w > 0) ? (int'(s.w) - 1) / 3 : 0;
        cap_y = (s.h > 0) ? (int'(s.h) - 1) / 3 : 0;
        if (c == 0)
        begin
            xi = $urandom_range(0, 65535);
            yi = $urandom_range(0, 65535);
        end
        else if (c <= 2 || s.w == 0 || s.h == 0)
        begin
            xi = left - 32 + int'($urandom_range(0, s.w + 64));
            yi = top - 32 + int'($urandom_range(0, s.h + 64));
        end
        else if (c <= 5)
        begin
            // hug the corners
            xi = $urandom_range(0, 1) ? left + int'($urandom_range(0, cap_x))
                                      : left + int'(s.w) - 1 - int'($urandom_range(0, cap_x));
            yi = $urandom_range(0, 1) ? top + int'($urandom_range(0, cap_y))
                                      : top + int'(s.h) - 1 - int'($urandom_range(0, cap_y));
        end
        else
        begin
            xi = left + int'($urandom_range(0, s.w - 1));
            yi = top + int'($urandom_range(0, s.h - 1));
        end
        x = xi[15:0];
        y = yi[15:0];
    endfunction

    initial
    begin
        shape_t             s;
        logic signed [15:0] x;
        logic signed [15:0] y;

        hits = new();
        steady_phase = 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        point_x <= '0;
        point_y <= '0;
        cfg_we <= 1'b0;
        cfg_index <= rrhit_pkg::REG_ORIGIN_X;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers straight out of reset: zero size, nothing is inside
        send_point(16'sd0, 16'sd0);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sh7fff, 16'sh8000);
        wait_idle();

        // hand-picked rectangle, bounds (-800,-480) to (800,480)
        s.ox = -16'sd800;
        s.oy = -16'sd480;
        s.w = 15'd1600;
        s.h = 15'd960;
        s.rx[CORNER_TL] = 15'd160;
        s.ry[CORNER_TL] = 15'd96;
        s.rx[CORNER_TR] = 15'd320;
        s.ry[CORNER_TR] = 15'd64;
        s.rx[CORNER_BR] = 15'd48;
        s.ry[CORNER_BR] = 15'd400;
        s.rx[CORNER_BL] = 15'd80;
        s.ry[CORNER_BL] = 15'd80;
        load_shape(s);
        send_point(-16'sd800, -16'sd480);   // top-left corner of the bounds, outside the arc
        send_point(16'sd0, 16'sd0);         // plain interior
        send_point(-16'sd801, 16'sd0);      // one left of the bounds
        send_point(16'sd800, 16'sd0);       // right edge is exclusive
        send_point(16'sd799, 16'sd0);       // last column, clear of the corners
        send_point(16'sd0, 16'sd479);       // last row
        send_point(16'sd0, 16'sd480);       // bottom edge is exclusive
        send_point(16'sd0, -16'sd480);      // first row
        send_point(-16'sd768, 16'sd464);    // bottom-left arc, exactly on the ellipse
        send_point(-16'sd769, 16'sd464);    // one step outside that
        send_point(-16'sd640, -16'sd480);   // just past the top-left corner region
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh7fff);
        send_point(16'sh7fff, 16'sh8000);
        wait_idle();

        // extremes: lowest origin, largest size, oversized and zero radii
        s.ox = 16'sh8000;
        s.oy = 16'sh8000;
        s.w = 15'h7fff;
        s.h = 15'h7fff;
        s.rx[CORNER_TL] = 15'h7fff;
        s.ry[CORNER_TL] = 15'h7fff;
        s.rx[CORNER_TR] = 15'd0;
        s.ry[CORNER_TR] = 15'h7fff;
        s.rx[CORNER_BR] = 15'h7fff;
        s.ry[CORNER_BR] = 15'd0;
        s.rx[CORNER_BL] = 15'h7fff;
        s.ry[CORNER_BL] = 15'h7fff;
        load_shape(s);
        send_point(16'sh8000, 16'sh8000);
        send_point(-16'sd2, -16'sd2);
        send_point(-16'sd1, -16'sd1);
        send_point(-16'sd16384, -16'sd16384);
        wait_idle();

        // highest origin: bounds run past the coordinate range, no rounding
        s.ox = 16'sh7fff;
        s.oy = 16'sh7fff;
        s.rx = '0;
        s.ry = '0;
        load_shape(s);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'sh7ffe, 16'sh7fff);

        // random rectangles, each with a burst of points
        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            s = rand_shape();
            load_shape(s);
            steady_phase = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 58; k++)
            begin
                rand_point(s, x, y);
                send_point(x, y);
                // now and then the sender holds back until the pipe is empty
                if ((p == 0 && k == 29) || $urandom_range(0, 39) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        hits.close();
        if (hits.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ rounded_rect_point_hit_test.f @@
src/rrhit_pkg.sv
src/rrhit_region.sv
src/rrhit_ellipse.sv
src/rounded_rect_point_hit_test.sv
verif/rounded_rect_point_hit_test_test.sv
